// ----- hdl/ajt_pkg.sv -----
package ajt_pkg;

    // Operation codes of an input item
    localparam logic [2:0] OP_WHEEL = 3'd0;
    localparam logic [2:0] OP_CONT  = 3'd1;
    localparam logic [2:0] OP_INCR  = 3'd2;
    localparam logic [2:0] OP_ABS   = 3'd3;
    localparam logic [2:0] OP_ABORT = 3'd4;
    localparam logic [2:0] OP_IDLE  = 3'd5;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_FRAC  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_SCALE = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_VEL_MODE    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCKING     = 3'd7;

    // Reset values of the registers that are not zero, and the wheel fraction of one
    localparam logic [31:0] ACCEL_LIMIT_RST = 32'h0001_0000;
    localparam logic [15:0] WHEEL_FRAC_RST  = 16'h8000;
    localparam logic [15:0] FRAC_ONE        = 16'h8000;

    // Divider steps for the stopping distance quotient
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [2:0]          op;
        logic signed [31:0]  wheel_counts;
        logic                teleop_mode;
        logic                motion_enabled;
        logic                homing_active;
        logic                wheel_enable;
        logic signed [31:0]  current_position;
        logic signed [31:0]  jog_speed;
        logic signed [31:0]  jog_distance;
        logic                abort_immediate;
    } t_in;

    typedef struct packed {
        logic signed [31:0]  target_position;
        logic [31:0]         planner_speed;
        logic [31:0]         planner_accel;
        logic                planner_enable;
        logic                keyboard_jog_active;
        logic                wheel_jog_active;
        logic                was_aborted;
        logic                zero_velocity;
        logic                accepted;
    } t_out;

    typedef struct packed {
        logic load;
        logic mul;
        logic pos;
        logic div_step;
        logic clamp;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic is_wheel;
        logic need_div;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/ajt_datapath.sv -----
module ajt_datapath
    import ajt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_in                    i_in_data,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output t_out                   o_out_data
);

    // Configuration registers
    logic signed [31:0] r_upper, r_lower, r_scale;
    logic [31:0]        r_speed_lim, r_accel_lim;
    logic [15:0]        r_frac;
    logic               r_vmode, r_lock;

    // Axis state
    logic signed [31:0] r_goal, n_goal;
    logic [31:0]        r_gspeed, n_gspeed, r_gaccel, n_gaccel;
    logic               r_pl, n_pl, r_kb, n_kb, r_wh, n_wh, r_seen, n_seen;
    logic signed [31:0] r_prev, n_prev;

    // Working registers
    t_in                r_item;
    logic [31:0]        r_acc;
    logic signed [63:0] r_prod;
    logic [63:0]        r_vsq;
    logic signed [65:0] r_pos;
    logic               r_big;
    logic [32:0]        r_rem;
    logic [31:0]        r_quo;
    logic               r_out_valid;
    t_out               r_out;

    logic [47:0]        frac_prod;
    logic [31:0]        acc_next;
    logic signed [31:0] wheel_delta;
    logic signed [63:0] ws_prod;
    logic [63:0]        vsq_next;
    logic [32:0]        div_den;
    logic [33:0]        rem_sh, rem_diff;
    logic               rem_ge;
    logic [32:0]        stop_span;
    logic signed [65:0] cur66, stop66, clamp_hi, clamp_lo, pos_clamped;
    logic               pos_ok;
    logic signed [33:0] kb_target;
    logic               kb_ok;
    logic [31:0]        jog_abs;
    logic               n_accepted, n_aborted, n_zero_vel;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper     <= '0;
            r_lower     <= '0;
            r_speed_lim <= '0;
            r_accel_lim <= ACCEL_LIMIT_RST;
            r_frac      <= WHEEL_FRAC_RST;
            r_scale     <= '0;
            r_vmode     <= 1'b0;
            r_lock      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_UPPER_LIMIT: r_upper     <= $signed(i_cfg_data);
                REG_LOWER_LIMIT: r_lower     <= $signed(i_cfg_data);
                REG_SPEED_LIMIT: r_speed_lim <= i_cfg_data;
                REG_ACCEL_LIMIT: r_accel_lim <= i_cfg_data;
                REG_WHEEL_FRAC:  r_frac      <= i_cfg_data[15:0];
                REG_WHEEL_SCALE: r_scale     <= $signed(i_cfg_data);
                REG_VEL_MODE:    r_vmode     <= i_cfg_data[0];
                REG_LOCKING:     r_lock      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Wheel acceleration, step distance and speed squared
    assign frac_prod   = 48'(r_frac) * 48'(r_accel_lim);
    assign acc_next    = (r_frac > FRAC_ONE) ? r_accel_lim : frac_prod[46:15];
    assign wheel_delta = r_item.wheel_counts - r_prev;
    assign ws_prod     = 64'(wheel_delta) * 64'(r_scale);
    assign vsq_next    = 64'(r_speed_lim) * 64'(r_speed_lim);

    // Restoring divider step: one quotient bit per cycle
    assign div_den  = {r_acc, 1'b0};
    assign rem_sh   = {r_rem, r_quo[31]};
    assign rem_ge   = rem_sh >= {1'b0, div_den};
    assign rem_diff = rem_sh - {1'b0, div_den};

    // Clamp to one stopping distance around the current position
    assign stop_span = r_big ? {1'b1, 32'h0} : {1'b0, r_quo};
    assign cur66     = 66'(r_item.current_position);
    assign stop66    = $signed(66'(stop_span));
    assign clamp_hi  = cur66 + stop66;
    assign clamp_lo  = cur66 - stop66;

    always_comb begin
        pos_clamped = r_pos;
        if (r_pos > clamp_hi) begin
            pos_clamped = clamp_hi;
        end else if (r_pos < clamp_lo) begin
            pos_clamped = clamp_lo;
        end
    end

    // Hold the item and run the wheel arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.mul) begin
            r_acc  <= acc_next;
            r_prod <= ws_prod;
            r_vsq  <= vsq_next;
        end
        if (i_cmd.pos) begin
            r_pos <= 66'(r_goal) + 66'(r_prod);
            r_big <= {1'b0, r_vsq[63:32]} >= div_den;
            r_rem <= {1'b0, r_vsq[63:32]};
            r_quo <= r_vsq[31:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_diff[32:0] : rem_sh[32:0];
            r_quo <= {r_quo[30:0], rem_ge};
        end
        if (i_cmd.clamp && o_sts.need_div) begin
            r_pos <= pos_clamped;
        end
    end

    // Limit checks and jog figures
    assign pos_ok    = (r_pos <= 66'(r_upper)) && (r_pos >= 66'(r_lower));
    assign kb_target = (r_item.jog_speed > 0) ? 34'(r_goal) + 34'(r_item.jog_distance)
                                              : 34'(r_goal) - 34'(r_item.jog_distance);
    assign kb_ok     = (kb_target <= 34'(r_upper)) && (kb_target >= 34'(r_lower));
    assign jog_abs   = (r_item.jog_speed < 0) ? 32'(-r_item.jog_speed) : r_item.jog_speed;

    // Next axis state for the item
    always_comb begin
        n_goal     = r_goal;
        n_gspeed   = r_gspeed;
        n_gaccel   = r_gaccel;
        n_pl       = r_pl;
        n_kb       = r_kb;
        n_wh       = r_wh;
        n_prev     = r_prev;
        n_seen     = r_seen;
        n_accepted = 1'b0;
        n_aborted  = 1'b0;
        n_zero_vel = 1'b0;
        case (r_item.op)
            OP_WHEEL: begin
                n_prev = r_item.wheel_counts;
                if (!r_seen) begin
                    n_seen = 1'b1;
                end else if (wheel_delta == 0) begin
                    n_accepted = 1'b0;
                end else if (!r_item.teleop_mode) begin
                    n_pl = 1'b0;
                end else if (!r_item.motion_enabled || !r_item.wheel_enable ||
                             r_item.homing_active || r_kb || r_lock) begin
                    n_accepted = 1'b0;
                end else if (pos_ok) begin
                    n_goal     = r_pos[31:0];
                    n_gspeed   = r_speed_lim;
                    n_gaccel   = r_acc;
                    n_wh       = 1'b1;
                    n_pl       = 1'b1;
                    n_accepted = 1'b1;
                end
            end
            OP_CONT: begin
                n_goal     = (r_item.jog_speed > 0) ? r_upper : r_lower;
                n_gspeed   = jog_abs;
                n_gaccel   = r_accel_lim;
                n_kb       = 1'b1;
                n_pl       = 1'b1;
                n_accepted = 1'b1;
            end
            OP_INCR, OP_ABS: begin
                if (r_item.op == OP_ABS) begin
                    n_kb = 1'b1;
                end
                if (kb_ok && !(r_item.op == OP_ABS && r_wh)) begin
                    n_goal     = kb_target[31:0];
                    n_gspeed   = jog_abs;
                    n_gaccel   = r_accel_lim;
                    n_kb       = 1'b1;
                    n_pl       = 1'b1;
                    n_accepted = 1'b1;
                end
            end
            OP_ABORT: begin
                n_aborted  = r_pl;
                n_pl       = 1'b0;
                n_kb       = 1'b0;
                n_wh       = 1'b0;
                n_zero_vel = r_item.abort_immediate;
            end
            OP_IDLE: begin
                n_kb = 1'b0;
                n_wh = 1'b0;
            end
            default: ;
        endcase
    end

    // Commit the state and load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal      <= '0;
            r_gspeed    <= '0;
            r_gaccel    <= '0;
            r_pl        <= 1'b0;
            r_kb        <= 1'b0;
            r_wh        <= 1'b0;
            r_prev      <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_goal      <= n_goal;
            r_gspeed    <= n_gspeed;
            r_gaccel    <= n_gaccel;
            r_pl        <= n_pl;
            r_kb        <= n_kb;
            r_wh        <= n_wh;
            r_prev      <= n_prev;
            r_seen      <= n_seen;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.target_position     <= n_goal;
            r_out.planner_speed       <= n_gspeed;
            r_out.planner_accel       <= n_gaccel;
            r_out.planner_enable      <= n_pl;
            r_out.keyboard_jog_active <= n_kb;
            r_out.wheel_jog_active    <= n_wh;
            r_out.was_aborted         <= n_aborted;
            r_out.zero_velocity       <= n_zero_vel;
            r_out.accepted            <= n_accepted;
        end
    end

    // Route the offered item: only looked at while a transfer is taken
    assign o_sts.is_wheel = (i_in_data.op == OP_WHEEL);
    assign o_sts.need_div = r_vmode && (r_acc != '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

// ----- hdl/ajt_ctrl.sv -----
module ajt_ctrl
    import ajt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_POS,
        S_DIV,
        S_CLAMP,
        S_COMMIT
    } t_state;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_in_ready, n_in_ready;

    // Next state
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_in_ready = r_in_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    n_state    = i_sts.is_wheel ? S_MUL : S_COMMIT;
                    n_in_ready = 1'b0;
                end
            end
            S_MUL: n_state = S_POS;
            S_POS: begin
                n_cnt   = '0;
                n_state = i_sts.need_div ? S_DIV : S_CLAMP;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: n_state = S_COMMIT;
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state    = S_IDLE;
                    n_in_ready = 1'b1;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    // Hold state and the ready flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_in_ready <= n_in_ready;
        end
    end

    // Commands to the datapath
    assign o_in_ready      = r_in_ready;
    assign o_cmd.load      = (r_state == S_IDLE) && i_in_valid && r_in_ready;
    assign o_cmd.mul       = (r_state == S_MUL);
    assign o_cmd.pos       = (r_state == S_POS);
    assign o_cmd.div_step  = (r_state == S_DIV);
    assign o_cmd.clamp     = (r_state == S_CLAMP);
    assign o_cmd.commit    = (r_state == S_COMMIT) && i_sts.out_free;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("commit into a full output register");
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) |=> (r_state == S_CLAMP))
        else $error("divider overran");
    a_load_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_MUL || r_state == S_COMMIT))
        else $error("load without start");

endmodule

// ----- hdl/axis_jog_target_manager.sv -----
// Channel  | Signals                               | Transfer when
// input    | i_in_valid, o_in_ready, i_in_data     | valid and ready high
// output   | o_out_valid, i_out_ready, o_out_data  | valid and ready high
// config   | i_cfg_we, i_cfg_index, i_cfg_data     | write enable high
//
// One item at a time. Non-wheel items go straight to commit; wheel items pass
// multiply, position, clamp and commit. In velocity mode the stopping distance
// comes from a restoring divider producing one quotient bit per cycle.
// A finished result sits in the output register while the next item is taken;
// a stalled output holds the commit of the following item.
// Reset is synchronous, active low; no clearing pass is needed.
module axis_jog_target_manager
    import ajt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in                    i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out                   o_out_data,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    ajt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ajt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- dv/axis_jog_target_manager_test.sv -----
`timescale 1ns / 100ps

module axis_jog_target_manager_test;
    import ajt_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_in                    i_in_data;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_out                   o_out_data;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    axis_jog_target_manager dut (.*);

    // Shadow copy of the axis settings and jog state
    logic [31:0] upper_lim, lower_lim, speed_lim, accel_lim, step_scale;
    logic [15:0] accel_frac;
    logic        vel_mode, locking;
    logic [31:0] goal_pos, goal_spd, goal_acc, last_counts;
    logic        plan_on, kb_act, wh_act, counts_valid;

    t_out        goal_queue[$];
    int          mismatches, results_seen, wheel_accepts, clamp_hits;
    bit          idle_in, idle_out, busy_stretch;

    // Directed stimulus, expected goal typed where obvious
    typedef struct {
        t_in   item;
        bit    has_known;
        t_out  known;
    } t_row;
    t_row directed_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("** axis_jog_target_manager: FAILED **");
        $finish;
    end

    function automatic bit within_soft(longint p);
        return p <= longint'($signed(upper_lim)) && p >= longint'($signed(lower_lim));
    endfunction

    function automatic bit kb_move(longint spd, longint ofs);
        longint g, t;
        g = longint'($signed(goal_pos));
        t = (spd > 0) ? g + ofs : g - ofs;
        if (!within_soft(t)) return 1'b0;
        goal_pos = t[31:0];
        goal_spd = (spd < 0) ? 32'(-spd) : 32'(spd);
        goal_acc = accel_lim;
        kb_act   = 1'b1;
        plan_on  = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit wheel_move(t_in it);
        logic [31:0] d32;
        longint      delta, pos, cur, stp;
        logic [63:0] acc, v;
        d32 = it.wheel_counts - last_counts;
        delta = longint'($signed(d32));
        if (accel_frac > FRAC_ONE) acc = 64'(accel_lim);
        else acc = (64'(accel_frac) * 64'(accel_lim)) >> 15;
        last_counts = it.wheel_counts;
        if (!counts_valid) begin
            counts_valid = 1'b1;
            return 1'b0;
        end
        if (delta == 0) return 1'b0;
        if (!it.teleop_mode) begin
            plan_on = 1'b0;
            return 1'b0;
        end
        if (!it.motion_enabled || !it.wheel_enable || it.homing_active) return 1'b0;
        if (kb_act || locking) return 1'b0;
        pos = longint'($signed(goal_pos)) + delta * longint'($signed(step_scale));
        if (vel_mode && acc != 0) begin
            v = 64'(speed_lim);
            stp = longint'((v * v) / (acc * 2));
            if (stp > 64'h1_0000_0000) stp = 64'h1_0000_0000;
            cur = longint'(it.current_position);
            if (pos > cur + stp) begin
                pos = cur + stp;
                clamp_hits++;
            end else if (pos < cur - stp) begin
                pos = cur - stp;
                clamp_hits++;
            end
        end
        if (!within_soft(pos)) return 1'b0;
        goal_pos = pos[31:0];
        goal_spd = speed_lim;
        goal_acc = acc[31:0];
        wh_act   = 1'b1;
        plan_on  = 1'b1;
        wheel_accepts++;
        return 1'b1;
    endfunction

    function automatic t_out predict_goal(t_in it);
        t_out   r;
        longint spd, ofs;
        bit     ok;
        ok = 1'b0;
        r  = '0;
        spd = longint'(it.jog_speed);
        ofs = longint'(it.jog_distance);
        case (it.op)
            OP_WHEEL: ok = wheel_move(it);
            OP_CONT: begin
                goal_pos = (spd > 0) ? upper_lim : lower_lim;
                goal_spd = (spd < 0) ? 32'(-spd) : 32'(spd);
                goal_acc = accel_lim;
                kb_act   = 1'b1;
                plan_on  = 1'b1;
                ok       = 1'b1;
            end
            OP_INCR: ok = kb_move(spd, ofs);
            OP_ABS: begin
                kb_act = 1'b1;
                if (!wh_act) ok = kb_move(spd, ofs);
            end
            OP_ABORT: begin
                r.was_aborted   = plan_on;
                r.zero_velocity = it.abort_immediate;
                plan_on = 1'b0;
                kb_act  = 1'b0;
                wh_act  = 1'b0;
            end
            OP_IDLE: begin
                kb_act = 1'b0;
                wh_act = 1'b0;
            end
            default: ;
        endcase
        r.target_position     = goal_pos;
        r.planner_speed       = goal_spd;
        r.planner_accel       = goal_acc;
        r.planner_enable      = plan_on;
        r.keyboard_jog_active = kb_act;
        r.wheel_jog_active    = wh_act;
        r.accepted            = ok;
        return r;
    endfunction

    // Check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (goal_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                if (o_out_data !== goal_queue[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", goal_queue[0], o_out_data);
                end
                void'(goal_queue.pop_front());
            end
        end
    end

    // Random back-pressure on the result side
    always @(posedge i_clk) begin
        i_out_ready <= busy_stretch ? 1'b1 : ($urandom_range(99) >= 27);
    end

    // Write one register; the caller drops the write enable after the last one
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            REG_UPPER_LIMIT: upper_lim  = val;
            REG_LOWER_LIMIT: lower_lim  = val;
            REG_SPEED_LIMIT: speed_lim  = val;
            REG_ACCEL_LIMIT: accel_lim  = val;
            REG_WHEEL_FRAC:  accel_frac = val[15:0];
            REG_WHEEL_SCALE: step_scale = val;
            REG_VEL_MODE:    vel_mode   = val[0];
            REG_LOCKING:     locking    = val[0];
            default: ;
        endcase
    endtask

    // Offer one item, predict it on transfer
    task automatic send_item(t_in it);
        while (!busy_stretch && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        goal_queue.push_back(predict_goal(it));
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (goal_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic t_in rand_item(bit wheel_bias);
        t_in it;
        it = '0;
        it.op               = wheel_bias && $urandom_range(99) < 55 ? OP_WHEEL
                              : 3'($urandom_range(7));
        it.wheel_counts     = last_counts + 32'($signed($urandom_range(16)) - 8);
        if ($urandom_range(19) == 0) it.wheel_counts = $urandom;
        it.teleop_mode      = $urandom_range(15) != 0;
        it.motion_enabled   = $urandom_range(15) != 0;
        it.homing_active    = $urandom_range(15) == 0;
        it.wheel_enable     = $urandom_range(15) != 0;
        it.current_position = $urandom_range(3) == 0 ? $urandom
                              : goal_pos + 32'($signed($urandom_range(1 << 20)) - (1 << 19));
        it.jog_speed        = $urandom;
        it.jog_distance     = $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 20);
        it.abort_immediate  = $urandom_range(1);
        return it;
    endfunction

    function automatic t_in mk(logic [2:0] op, logic [31:0] cnt, logic [31:0] spd,
                               logic [31:0] dist_in);
        t_in it;
        it = '0;
        it.op = op;
        it.wheel_counts = cnt;
        it.teleop_mode = 1'b1;
        it.motion_enabled = 1'b1;
        it.wheel_enable = 1'b1;
        it.jog_speed = spd;
        it.jog_distance = dist_in;
        return it;
    endfunction

    function automatic void add_row(t_in it, bit known, t_out k);
        t_row r;
        r.item = it;
        r.has_known = known;
        r.known = k;
        directed_rows.push_back(r);
    endfunction

    // Compare the typed-in expectation with the prediction just queued
    function automatic bit predict_goal_check(t_out known);
        if (goal_queue[$] !== known) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row: expected %p, predicted %p", known, goal_queue[$]);
        end
        return 1'b0;
    endfunction

    initial begin
        t_out k;
        t_in  it;
        int   phase, n;

        i_rst_n = 1'b0;  i_in_valid = 1'b0;  i_in_data = '0;
        i_out_ready = 1'b1;  i_cfg_we = 1'b0;  i_cfg_index = '0;  i_cfg_data = '0;
        mismatches = 0;  results_seen = 0;  wheel_accepts = 0;  clamp_hits = 0;
        busy_stretch = 1'b0;
        upper_lim = '0;  lower_lim = '0;  speed_lim = '0;  accel_lim = ACCEL_LIMIT_RST;
        accel_frac = WHEEL_FRAC_RST;  step_scale = '0;  vel_mode = 1'b0;  locking = 1'b0;
        goal_pos = '0;  goal_spd = '0;  goal_acc = '0;  last_counts = '0;
        plan_on = 1'b0;  kb_act = 1'b0;  wh_act = 1'b0;  counts_valid = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: limits at zero after reset, then extremes
        k = '0;
        k.planner_enable = 1'b1; k.keyboard_jog_active = 1'b1; k.accepted = 1'b1;
        k.planner_speed = 32'd5; k.planner_accel = ACCEL_LIMIT_RST;
        add_row(mk(OP_CONT, 0, 32'd5, 0), 1'b1, k);
        k = '0; k.planner_speed = 32'd5; k.planner_accel = ACCEL_LIMIT_RST;
        k.was_aborted = 1'b1; k.zero_velocity = 1'b1;
        it = mk(OP_ABORT, 0, 0, 0); it.abort_immediate = 1'b1;
        add_row(it, 1'b1, k);
        k.was_aborted = 1'b0; k.zero_velocity = 1'b0;
        add_row(mk(OP_ABORT, 0, 0, 0), 1'b1, k);
        add_row(mk(3'd6, 0, 0, 0), 1'b1, k);
        add_row(mk(3'd7, 32'hffff_ffff, 0, 0), 1'b1, k);
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item);
            if (directed_rows[i].has_known && predict_goal_check(directed_rows[i].known))
                ;
        end
        drain();

        write_reg(REG_UPPER_LIMIT, 32'h7fff_ffff);
        write_reg(REG_LOWER_LIMIT, 32'h8000_0000);
        write_reg(REG_SPEED_LIMIT, 32'hffff_ffff);
        write_reg(REG_ACCEL_LIMIT, 32'd1);
        write_reg(REG_WHEEL_FRAC, 32'hffff);
        write_reg(REG_WHEEL_SCALE, 32'h7fff_ffff);
        write_reg(REG_VEL_MODE, 32'd1);
        write_reg(REG_LOCKING, 32'd0);
        i_cfg_we <= 1'b0;
        directed_rows.delete();
        add_row(mk(OP_WHEEL, 32'h7fff_ffff, 0, 0), 1'b0, k);
        add_row(mk(OP_WHEEL, 32'h8000_0000, 0, 0), 1'b0, k);
        add_row(mk(OP_WHEEL, 32'h8000_0000, 0, 0), 1'b0, k);
        add_row(mk(OP_IDLE, 0, 0, 0), 1'b0, k);
        add_row(mk(OP_WHEEL, 32'h8000_0005, 0, 0), 1'b0, k);
        it = mk(OP_WHEEL, 32'h0, 0, 0); it.teleop_mode = 1'b0;
        add_row(it, 1'b0, k);
        add_row(mk(OP_INCR, 0, 32'h8000_0000, 32'h7fff_ffff), 1'b0, k);
        add_row(mk(OP_INCR, 0, 32'h7fff_ffff, 32'h8000_0000), 1'b0, k);
        add_row(mk(OP_CONT, 0, 32'h8000_0000, 0), 1'b0, k);
        add_row(mk(OP_ABS, 0, 32'd1, 32'd100), 1'b0, k);
        add_row(mk(OP_IDLE, 0, 0, 0), 1'b0, k);
        add_row(mk(OP_WHEEL, 32'h3, 0, 0), 1'b0, k);
        add_row(mk(OP_ABS, 0, 32'd1, 32'd100), 1'b0, k);
        add_row(mk(OP_ABORT, 0, 0, 0), 1'b0, k);
        foreach (directed_rows[i]) send_item(directed_rows[i].item);
        drain();

        // Random phases over several settings
        for (phase = 0; phase < 8; phase++) begin
            write_reg(REG_UPPER_LIMIT, phase == 7 ? 32'h7fff_ffff : 32'($urandom_range(1 << 26)));
            write_reg(REG_LOWER_LIMIT, phase == 7 ? 32'h8000_0000 : -32'($urandom_range(1 << 26)));
            write_reg(REG_SPEED_LIMIT, phase[0] ? $urandom : $urandom_range(1 << 18));
            write_reg(REG_ACCEL_LIMIT, phase == 3 ? 32'hffff_ffff : 32'($urandom_range(1 << 20, 1)));
            write_reg(REG_WHEEL_FRAC, phase == 2 ? 32'd0 : 32'($urandom_range(16'hffff)));
            write_reg(REG_WHEEL_SCALE, phase == 5 ? 32'h8000_0000
                                       : 32'($signed($urandom_range(1 << 16)) - (1 << 15)));
            write_reg(REG_VEL_MODE, 32'(phase % 3 != 0));
            write_reg(REG_LOCKING, 32'(phase == 4));
            i_cfg_we <= 1'b0;
            busy_stretch = (phase == 6);
            for (n = 0; n < 78; n++) send_item(rand_item(1'b1));
            drain();
        end
        busy_stretch = 1'b0;

        $display("Items cover all ops, %0d results, %0d wheel moves accepted, %0d clamped.",
                 results_seen, wheel_accepts, clamp_hits);
        if (mismatches == 0) begin
            $display("** axis_jog_target_manager: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** axis_jog_target_manager: FAILED **");
        end
        $finish;
    end

endmodule
